/* rtl/core/pba_pkg.sv */
// Shared types and codes for the page bitmap allocator.
package pba_pkg;

    localparam int CNT_W  = 17;
    localparam int IDX_W  = 16;
    localparam int LG_W   = 5;
    localparam int ST_W   = 3;
    localparam int FAIL_W = 32;
    localparam int WORD_W = 64;
    localparam int MAX_PAGES = 65536;
    localparam logic [LG_W-1:0] MAX_ALIGN_LOG2 = 5'd16;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ALIGN = 2'd2;
    localparam logic [1:0] OP_AVAIL = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_BADCNT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [ST_W-1:0] ST_OOB      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTALLOC = 3'd4;
    localparam logic [ST_W-1:0] ST_BADALIGN = 3'd5;

    localparam logic REG_TOTAL    = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    typedef enum logic [2:0] {K_SCAN, K_TEST, K_MARK, K_RELEASE, K_AVAIL} kind_t;
    typedef enum logic [1:0] {S_NFI, S_ZERO, S_IDX, S_FIRST} sel_t;
    typedef enum logic [2:0] {P_FAIL, P_SCAN0, P_SCAN2, P_FREE, P_AVAIL} pre_t;

    typedef struct packed {
        logic            load;
        logic            clr;
        logic            rd;
        logic            lat;
        logic            step;
        logic            wb;
        logic            start;
        sel_t            sel;
        kind_t           kind;
        logic            fin;
        logic [ST_W-1:0] fin_st;
        logic            emit;
    } cmd_t;

    typedef struct packed {
        logic            clr_last;
        pre_t            pre;
        logic [ST_W-1:0] pre_st;
        kind_t           kind;
        logic            ptr_out;
        logic            found;
        logic            scan_last;
        logic            cnt_last;
        logic            word_end;
        logic            hit_free;
        logic            walk_done;
    } sts_t;

endpackage

/* rtl/core/pba_ctrl.sv */
// Sequencer for the page bitmap allocator: clear pass, checks, bitmap walks.
module pba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic          out_free,
    input  pba_pkg::sts_t sts,
    output pba_pkg::cmd_t cmd,
    output logic          idle
);
    import pba_pkg::*;

    typedef enum logic [3:0] {
        CLR, IDLE, CHK, RD, LAT, STEP, WB, GO_MARK, DONE
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    assign idle = (state_reg == IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            CLR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) state_next = IDLE;
            end
            IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = CHK;
                end
            end
            CHK: begin
                case (sts.pre)
                    P_FAIL: begin
                        cmd.fin    = 1'b1;
                        cmd.fin_st = sts.pre_st;
                        state_next = DONE;
                    end
                    P_SCAN0: begin
                        cmd.start = 1'b1; cmd.sel = S_NFI; cmd.kind = K_SCAN;
                        pass_next = 1'b0; state_next = RD;
                    end
                    P_SCAN2: begin
                        cmd.start = 1'b1; cmd.sel = S_ZERO; cmd.kind = K_SCAN;
                        pass_next = 1'b1; state_next = RD;
                    end
                    P_FREE: begin
                        cmd.start = 1'b1; cmd.sel = S_IDX; cmd.kind = K_TEST;
                        state_next = RD;
                    end
                    P_AVAIL: begin
                        cmd.start = 1'b1; cmd.sel = S_IDX; cmd.kind = K_AVAIL;
                        state_next = RD;
                    end
                    default: state_next = IDLE;
                endcase
            end
            RD: begin
                if (sts.kind == K_SCAN && sts.ptr_out) begin
                    if (!pass_reg) begin
                        // next-fit pass exhausted: retry from page zero
                        cmd.start = 1'b1; cmd.sel = S_ZERO; cmd.kind = K_SCAN;
                        pass_next = 1'b1;
                    end else begin
                        cmd.fin = 1'b1; cmd.fin_st = ST_NOSPACE;
                        state_next = DONE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = LAT;
                end
            end
            LAT: begin
                cmd.lat    = 1'b1;
                state_next = STEP;
            end
            STEP: begin
                cmd.step = 1'b1;
                case (sts.kind)
                    K_SCAN: begin
                        if (sts.found) begin
                            state_next = GO_MARK;
                        end else if (sts.scan_last) begin
                            if (!pass_reg) begin
                                cmd.start = 1'b1; cmd.sel = S_ZERO; cmd.kind = K_SCAN;
                                pass_next = 1'b1; state_next = RD;
                            end else begin
                                cmd.fin = 1'b1; cmd.fin_st = ST_NOSPACE;
                                state_next = DONE;
                            end
                        end else if (sts.word_end) begin
                            state_next = RD;
                        end
                    end
                    K_TEST: begin
                        if (sts.hit_free) begin
                            cmd.fin = 1'b1; cmd.fin_st = ST_NOTALLOC;
                            state_next = DONE;
                        end else if (sts.cnt_last) begin
                            cmd.start = 1'b1; cmd.sel = S_IDX; cmd.kind = K_RELEASE;
                            state_next = RD;
                        end else if (sts.word_end) begin
                            state_next = RD;
                        end
                    end
                    default: begin
                        if (sts.cnt_last || sts.word_end) state_next = WB;
                    end
                endcase
            end
            WB: begin
                cmd.wb = 1'b1;
                if (sts.walk_done) begin
                    cmd.fin = 1'b1; cmd.fin_st = ST_OK;
                    state_next = DONE;
                end else begin
                    state_next = RD;
                end
            end
            GO_MARK: begin
                cmd.start = 1'b1; cmd.sel = S_FIRST; cmd.kind = K_MARK;
                state_next = RD;
            end
            DONE: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLR;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

/* rtl/core/pba_dp.sv */
// Datapath: page bitmap memory, walk pointers, run counter and page counters.
module pba_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pba_pkg::cmd_t                cmd,
    output pba_pkg::sts_t                sts,
    input  logic [1:0]                   in_op,
    input  logic [pba_pkg::CNT_W-1:0]    in_cnt,
    input  logic [pba_pkg::IDX_W-1:0]    in_idx,
    input  logic [pba_pkg::LG_W-1:0]     in_lg,
    input  logic [pba_pkg::CNT_W-1:0]    tot,
    input  logic [pba_pkg::CNT_W-1:0]    rsv_limit,
    output logic [pba_pkg::ST_W-1:0]     res_status,
    output logic [pba_pkg::IDX_W-1:0]    res_first,
    output logic [pba_pkg::CNT_W-1:0]    res_free,
    output logic [pba_pkg::CNT_W-1:0]    res_used,
    output logic [pba_pkg::FAIL_W-1:0]   res_failed
);
    import pba_pkg::*;

    localparam int WORDS = MAX_PAGES / WORD_W;
    localparam int AW    = $clog2(WORDS);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] word_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     clr_reg;

    logic [1:0]        op_reg;
    logic [CNT_W-1:0]  cnt_reg, ptr_reg, run_reg, rem_reg, first_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LG_W-1:0]   lg_reg;
    kind_t             kind_reg;
    logic [CNT_W-1:0]  free_reg, used_reg, nfi_reg;
    logic [FAIL_W-1:0] failed_reg;

    logic              cur_bit;
    logic [CNT_W-1:0]  run_new, s_start, amask, start_val, nf_end;
    logic [CNT_W:0]    range_end;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    pre_t              pre_c;
    logic [ST_W-1:0]   pre_st_c;

    assign cur_bit   = word_reg[ptr_reg[5:0]];
    assign run_new   = cur_bit ? '0 : run_reg + 1'b1;
    assign s_start   = ptr_reg + 1'b1 - cnt_reg;
    assign amask     = (op_reg == OP_ALIGN) ? (CNT_W'(1) << lg_reg) - 1'b1 : '0;
    assign range_end = {1'b0, idx_reg} + {1'b0, cnt_reg};
    assign nf_end    = first_reg + cnt_reg;

    always_comb begin
        case (cmd.sel)
            S_NFI:   start_val = nfi_reg;
            S_ZERO:  start_val = '0;
            S_IDX:   start_val = {1'b0, idx_reg};
            default: start_val = first_reg;
        endcase
    end

    // admission checks on the latched request
    always_comb begin
        pre_c    = P_FAIL;
        pre_st_c = ST_OK;
        if (cnt_reg == '0) begin
            pre_st_c = ST_BADCNT;
        end else if (op_reg == OP_ALLOC) begin
            if (cnt_reg > free_reg || cnt_reg > tot) pre_st_c = ST_NOSPACE;
            else pre_c = P_SCAN0;
        end else if (op_reg == OP_ALIGN) begin
            if (lg_reg > MAX_ALIGN_LOG2)  pre_st_c = ST_BADALIGN;
            else if (cnt_reg > tot)       pre_st_c = ST_NOSPACE;
            else                          pre_c = P_SCAN2;
        end else if (range_end > {1'b0, tot}) begin
            pre_st_c = ST_OOB;
        end else if (op_reg == OP_FREE) begin
            pre_c = P_FREE;
        end else begin
            pre_c = P_AVAIL;
        end
    end

    assign sts.pre       = pre_c;
    assign sts.pre_st    = pre_st_c;
    assign sts.clr_last  = (clr_reg == AW'(WORDS - 1));
    assign sts.kind      = kind_reg;
    assign sts.ptr_out   = (ptr_reg >= tot);
    assign sts.found     = !cur_bit && (run_new >= cnt_reg) && ((s_start & amask) == '0);
    assign sts.scan_last = (ptr_reg + 1'b1 >= tot);
    assign sts.cnt_last  = (rem_reg == CNT_W'(1));
    assign sts.word_end  = (ptr_reg[5:0] == 6'd63);
    assign sts.hit_free  = !cur_bit;
    assign sts.walk_done = (rem_reg == '0);

    assign we    = cmd.clr | cmd.wb;
    assign waddr = cmd.clr ? clr_reg : addr_reg;
    assign wdata = cmd.clr ? '1 : word_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd) rdata_reg <= mem[AW'(ptr_reg >> 6)];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            cnt_reg <= in_cnt;
            idx_reg <= in_idx;
            lg_reg  <= in_lg;
        end
        if (cmd.rd) addr_reg <= AW'(ptr_reg >> 6);
        if (cmd.lat) word_reg <= rdata_reg;
        if (cmd.step) begin
            ptr_reg <= ptr_reg + 1'b1;
            run_reg <= run_new;
            rem_reg <= rem_reg - 1'b1;
            if (kind_reg == K_SCAN && sts.found) first_reg <= s_start;
            case (kind_reg)
                K_MARK:    word_reg[ptr_reg[5:0]] <= 1'b1;
                K_RELEASE: word_reg[ptr_reg[5:0]] <= 1'b0;
                K_AVAIL:   if (ptr_reg >= rsv_limit) word_reg[ptr_reg[5:0]] <= 1'b0;
                default:   ;
            endcase
        end
        if (cmd.start) begin
            ptr_reg <= start_val;
            run_reg <= '0;
            rem_reg <= cnt_reg;
        end
        if (cmd.fin) begin
            res_status <= cmd.fin_st;
            res_first  <= (cmd.fin_st == ST_OK && kind_reg == K_MARK) ?
                          IDX_W'(first_reg) : '0;
        end
    end

    // control and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg    <= '0;
            kind_reg   <= K_SCAN;
            free_reg   <= '0;
            used_reg   <= '0;
            nfi_reg    <= '0;
            failed_reg <= '0;
        end else begin
            if (cmd.clr) clr_reg <= clr_reg + 1'b1;
            if (cmd.start) kind_reg <= cmd.kind;
            if (cmd.step && kind_reg == K_AVAIL && cur_bit && ptr_reg >= rsv_limit)
                free_reg <= free_reg + 1'b1;
            if (cmd.fin) begin
                if (cmd.fin_st == ST_NOSPACE ||
                    (cmd.fin_st == ST_BADCNT && op_reg == OP_ALLOC))
                    failed_reg <= failed_reg + 1'b1;
                if (cmd.fin_st == ST_OK && kind_reg == K_MARK) begin
                    free_reg <= free_reg - cnt_reg;
                    used_reg <= used_reg + cnt_reg;
                    if (op_reg == OP_ALLOC) nfi_reg <= (nf_end >= tot) ? '0 : nf_end;
                end
                if (cmd.fin_st == ST_OK && kind_reg == K_RELEASE) begin
                    free_reg <= free_reg + cnt_reg;
                    used_reg <= used_reg - cnt_reg;
                end
            end
        end
    end

    assign res_free   = free_reg;
    assign res_used   = used_reg;
    assign res_failed = failed_reg;

endmodule

/* rtl/core/page_bitmap_allocator_core.sv */
// A refused request passes check and result; a walk adds read and latch per bitmap word,
// a step per page and a write-back per word; an alloc adds a claim start, a next-fit index
// past the end a restart. A next-fit alloc may visit every page twice. Throughput: one
// request at a time; the walk, one page a cycle between word reads and write-backs, sets
// it. Reset: synchronous, active low; a clear pass over MAX_PAGES/64 = 1024 words marks
// all pages used while s_tready stays low. The result register lets the next request start.
module page_bitmap_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op[1:0], page_count[18:2], page_index[34:19],
                                   // align_log2[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // status[2:0], first[18:3], free_count[35:19],
                                   // used_count[52:36], failed_count[84:53], zeros above
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pba_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic              idle, accept, out_free;
    logic [CNT_W-1:0]  total_reg, rsv_reg, tot;
    logic              m_valid_reg;
    logic [87:0]       m_data_reg;
    logic [ST_W-1:0]   res_status;
    logic [IDX_W-1:0]  res_first;
    logic [CNT_W-1:0]  res_free, res_used;
    logic [FAIL_W-1:0] res_failed;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_RESERVED) ? {15'd0, rsv_reg} : {15'd0, total_reg};
    assign tot      = ({15'd0, total_reg} > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_reg;
    assign s_tready = idle;
    assign accept   = s_tvalid & idle;
    assign out_free = !m_valid_reg | m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= CNT_W'(65536);
            rsv_reg   <= CNT_W'(4096);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_RESERVED) rsv_reg <= pwdata[CNT_W-1:0];
            else                          total_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit)
            m_data_reg <= {3'd0, res_failed, res_used, res_free, res_first, res_status};
    end

    pba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    pba_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tdata[1:0]),
        .in_cnt     (s_tdata[18:2]),
        .in_idx     (s_tdata[34:19]),
        .in_lg      (s_tdata[39:35]),
        .tot        (tot),
        .rsv_limit  (rsv_reg),
        .res_status (res_status),
        .res_first  (res_first),
        .res_free   (res_free),
        .res_used   (res_used),
        .res_failed (res_failed)
    );

endmodule

/* rtl/core/pba_checker.sv */
// Port-level checks for the allocator core, bound to the top level.
module pba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);
    import pba_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_BADALIGN)
        else $error("status code out of range");

    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[18:3] == '0)
        else $error("first page set on a failed request");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while the previous one is in flight");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/page_bitmap_allocator_core_test.sv */
// Self-checking bench for the page bitmap allocator core: random and directed requests.
`timescale 1ns / 100ps

module page_bitmap_allocator_core_test;
    import pba_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [16:0] cnt;
        logic [15:0] idx;
        logic [4:0]  lg;
    } page_req_t;

    typedef struct {
        logic [2:0]  st;
        logic [15:0] first;
        logic [16:0] free_c;
        logic [16:0] used_c;
        logic [31:0] fail_c;
    } page_resp_t;

    typedef struct {
        int first;
        int cnt;
    } page_run_t;

    class alloc_scoreboard;
        bit        page_map[65536];
        int        cfg_total;
        int        reserved_limit;
        int        next_fit;
        bit [16:0] free_ctr;
        bit [16:0] used_ctr;
        bit [16:0] rsv_ctr;
        bit [31:0] fail_ctr;
        page_resp_t pending[$];
        int        errors;

        function new();
            foreach (page_map[i]) page_map[i] = 1'b1;
            cfg_total = 65536;
            reserved_limit = 4096;
            next_fit = 0;
            free_ctr = 0;
            used_ctr = 0;
            rsv_ctr = 0;
            fail_ctr = 0;
            errors = 0;
        endfunction

        function int find_run(int from, int cnt, int tot);
            int run;
            run = 0;
            for (int p = from; p < tot; p++) begin
                if (page_map[p]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == cnt) return p + 1 - cnt;
                end
            end
            return -1;
        endfunction

        function int find_aligned(int cnt, int lg, int tot);
            int mask;
            int run_start;
            bit in_run;
            int s;
            mask = (1 << lg) - 1;
            run_start = 0;
            in_run = 0;
            for (int p = 0; p < tot; p++) begin
                if (page_map[p]) begin
                    in_run = 0;
                    continue;
                end
                if (!in_run) begin
                    in_run = 1;
                    run_start = p;
                end
                if (p + 1 >= cnt) begin
                    s = p + 1 - cnt;
                    if (s >= run_start && (s & mask) == 0) return s;
                end
            end
            return -1;
        endfunction

        function void take_run(int first, int cnt);
            for (int k = 0; k < cnt; k++) page_map[first + k] = 1'b1;
            free_ctr = free_ctr - cnt[16:0];
            used_ctr = used_ctr + cnt[16:0];
        endfunction

        // Works out the response to one accepted beat and queues it.
        function page_resp_t note_request(page_req_t r);
            page_resp_t e;
            int tot, cnt, idx, f;
            bit all_used;
            tot = cfg_total > 65536 ? 65536 : cfg_total;
            cnt = int'(r.cnt);
            idx = int'(r.idx);
            e.st = ST_OK;
            e.first = '0;
            if (cnt == 0) begin
                e.st = ST_BADCNT;
                if (r.op == OP_ALLOC) fail_ctr++;
            end else if (r.op == OP_ALLOC) begin
                f = -1;
                if (cnt <= free_ctr && cnt <= tot) begin
                    f = find_run(next_fit, cnt, tot);
                    if (f < 0) f = find_run(0, cnt, tot);
                end
                if (f < 0) begin
                    e.st = ST_NOSPACE;
                    fail_ctr++;
                end else begin
                    e.first = f[15:0];
                    take_run(f, cnt);
                    next_fit = (f + cnt) % tot;
                end
            end else if (r.op == OP_ALIGN) begin
                if (r.lg > MAX_ALIGN_LOG2) begin
                    e.st = ST_BADALIGN;
                end else begin
                    f = cnt <= tot ? find_aligned(cnt, int'(r.lg), tot) : -1;
                    if (f < 0) begin
                        e.st = ST_NOSPACE;
                        fail_ctr++;
                    end else begin
                        e.first = f[15:0];
                        take_run(f, cnt);
                    end
                end
            end else if (idx + cnt > tot) begin
                e.st = ST_OOB;
            end else if (r.op == OP_FREE) begin
                all_used = 1;
                for (int k = 0; k < cnt; k++)
                    if (!page_map[idx + k]) all_used = 0;
                if (!all_used) begin
                    e.st = ST_NOTALLOC;
                end else begin
                    for (int k = 0; k < cnt; k++) page_map[idx + k] = 1'b0;
                    free_ctr = free_ctr + cnt[16:0];
                    used_ctr = used_ctr - cnt[16:0];
                end
            end else begin
                for (int p = idx; p < idx + cnt; p++) begin
                    if (!page_map[p]) continue;
                    if (p < reserved_limit) begin
                        rsv_ctr++;
                    end else begin
                        page_map[p] = 1'b0;
                        free_ctr++;
                    end
                end
            end
            e.free_c = free_ctr;
            e.used_c = used_ctr;
            e.fail_c = fail_ctr;
            pending.push_back(e);
            return e;
        endfunction

        function void report(string what, longint exp_v, longint act_v);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch %s: expected %0d got %0d", $realtime, what,
                         exp_v, act_v);
        endfunction

        function void check_response(logic [87:0] d);
            page_resp_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("%0t response beat with nothing pending", $realtime);
                return;
            end
            e = pending.pop_front();
            if (d[2:0] !== e.st) report("status", e.st, d[2:0]);
            if (d[18:3] !== e.first) report("start page", e.first, d[18:3]);
            if (d[35:19] !== e.free_c) report("free_count", e.free_c, d[35:19]);
            if (d[52:36] !== e.used_c) report("used_count", e.used_c, d[52:36]);
            if (d[84:53] !== e.fail_c) report("failed_count", e.fail_c, d[84:53]);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // op, page_count, page_index, align_log2
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // status, first, free_count, used_count, failed_count
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cur_total;
    page_run_t   live_runs[$];

    page_bitmap_allocator_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

    // Response side: random back-pressure, check every accepted beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_response(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic reg_write(input logic idx_bit, input int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx_bit, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx_bit == REG_TOTAL) sb.cfg_total = value & 32'h1FFFF;
        else sb.reserved_limit = value & 32'h1FFFF;
        @(posedge aclk);
    endtask

    // Called straight after an accepting edge: drops the request so it is not taken again.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_config(input int total, input int reserved);
        wait_drained();
        reg_write(REG_TOTAL, total);
        reg_write(REG_RESERVED, reserved);
        cur_total = total > 65536 ? 65536 : total;
        live_runs.delete();
    endtask

    task automatic send_req(input logic [1:0] op, input int cnt, input int idx,
                            input int lg);
        page_req_t r;
        page_resp_t e;
        page_run_t run;
        r.op = op;
        r.cnt = cnt[16:0];
        r.idx = idx[15:0];
        r.lg = lg[4:0];
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.lg, r.idx, r.cnt, r.op};
        do @(posedge aclk); while (!s_tready);
        e = sb.note_request(r);
        if (e.st == ST_OK && (op == OP_ALLOC || op == OP_ALIGN)) begin
            run.first = int'(e.first);
            run.cnt = cnt;
            live_runs.push_back(run);
        end
    endtask

    task automatic random_phase(input int n);
        int pick, k, hi;
        page_run_t run;
        hi = cur_total < 1 ? 1 : cur_total;
        send_req(OP_AVAIL, cur_total, 0, 0);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60 && pick >= 35 && live_runs.size() == 0) pick = 0;
            if (pick < 35) begin
                send_req(OP_ALLOC, $urandom_range(0, 9) == 0 ? $urandom_range(1, hi + 1)
                                                            : $urandom_range(1, 6), 0, 0);
            end else if (pick < 60) begin
                k = $urandom_range(0, live_runs.size() - 1);
                run = live_runs[k];
                if ($urandom_range(0, 4) != 0) begin
                    live_runs.delete(k);
                    send_req(OP_FREE, run.cnt, run.first, 0);
                end else begin
                    // shifted free, usually hits a free page
                    send_req(OP_FREE, run.cnt, run.first + 1, 0);
                end
            end else if (pick < 75) begin
                send_req(OP_ALIGN, $urandom_range(1, 8), 0,
                         $urandom_range(0, 19) == 0 ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 6));
            end else if (pick < 85) begin
                send_req(OP_AVAIL, $urandom_range(1, 16), $urandom_range(0, hi - 1), 0);
            end else begin
                send_req(2'($urandom_range(0, 3)), $urandom_range(0, hi + 2),
                         $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, hi),
                         $urandom_range(0, 31));
            end
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 13;
        recv_idle_pct = 67;
        cur_total = 65536;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset configuration, bitmap all used.
        send_req(OP_ALLOC, 0, 0, 0);
        send_req(OP_FREE, 0, 0, 0);
        send_req(OP_ALIGN, 0, 0, 0);
        send_req(OP_AVAIL, 0, 0, 0);
        send_req(OP_ALLOC, 1, 0, 0);              // more than the free counter
        send_req(OP_ALIGN, 1, 0, 17);
        send_req(OP_ALIGN, 1, 0, 31);
        send_req(OP_FREE, 2, 65535, 0);           // runs past the end
        send_req(OP_AVAIL, 2, 65535, 0);
        send_req(OP_AVAIL, 200, 4000, 0);         // straddles the reserved limit
        send_req(OP_FREE, 1, 4100, 0);            // page already free
        send_req(OP_ALLOC, 1, 0, 0);
        send_req(OP_ALIGN, 4, 0, 16);             // no aligned run
        send_req(OP_ALLOC, 65536, 0, 0);
        send_req(OP_ALIGN, 65536, 0, 0);
        send_req(OP_AVAIL, 65536, 0, 0);
        send_req(OP_FREE, 1, 65535, 0);
        send_req(OP_ALLOC, 60000, 0, 0);
        send_req(OP_ALIGN, 1, 0, 15);
        send_req(OP_FREE, 60000, 4097, 0);

        set_config(300, 16);
        random_phase(170);

        send_idle_pct = 67;
        recv_idle_pct = 13;
        set_config(64, 0);                        // next-fit index left stale
        random_phase(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(512, 65536);
        random_phase(160);

        set_config(0, 100);
        send_req(OP_ALLOC, 1, 0, 0);
        send_req(OP_ALIGN, 1, 0, 0);
        send_req(OP_FREE, 1, 0, 0);
        send_req(OP_AVAIL, 1, 0, 0);

        set_config(131071, 0);                    // beyond the maximum, clamps
        send_req(OP_AVAIL, 8, 65528, 0);
        send_req(OP_ALLOC, 3, 0, 0);
        send_req(OP_ALIGN, 2, 0, 3);
        send_req(OP_FREE, 3, 65528, 0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pba_pkg.sv
rtl/core/pba_ctrl.sv
rtl/core/pba_dp.sv
rtl/core/page_bitmap_allocator_core.sv
rtl/core/pba_checker.sv
verif/page_bitmap_allocator_core_test.sv
